// ----- hw/rtl/table_driven_ahdsr_envelope_core_defines.svh -----
// Assertion macros used by the envelope core checker.
`ifndef TABLE_DRIVEN_AHDSR_ENVELOPE_CORE_DEFINES_SVH
`define TABLE_DRIVEN_AHDSR_ENVELOPE_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define TDAE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("envelope core check failed");

// Consequent checked in the cycle after the antecedent.
`define TDAE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("envelope core check failed");

`endif

// ----- hw/rtl/tdae_pkg.sv -----
// Shared constants, types and control/status words of the envelope core.
package tdae_pkg;

	localparam int NUM_POINTS = 1024;
	localparam int PT_W       = $clog2(NUM_POINTS);

	localparam int LEN_W      = 14;
	localparam int LVL_W      = 17;
	localparam int IDX_W      = 10;
	localparam int TIME_W     = 32;
	localparam int TOT_W      = 16;
	localparam int Q_FRAC     = 16;
	localparam int CFG_IDX_W  = 3;

	// serial divider: dividend holds {level, Q16 fraction}, divisor up to a level
	localparam int DIV_W      = LVL_W + Q_FRAC;
	localparam int DVS_W      = LVL_W;
	localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

	localparam logic [LVL_W-1:0]   ONE_Q16  = LVL_W'(1 << Q_FRAC);
	localparam logic [2*LVL_W-1:0] HALF_Q16 = (2*LVL_W)'(1 << (Q_FRAC - 1));

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ATTACK  = 3'd0,
		CFG_HOLD    = 3'd1,
		CFG_DECAY   = 3'd2,
		CFG_RELEASE = 3'd3,
		CFG_SUSTAIN = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		DIV_POS,
		DIV_INTERP,
		DIV_RATIO
	} div_sel_t;

	typedef enum logic [1:0] {
		MUL_Y1,
		MUL_Y2,
		MUL_RATIO
	} mul_sel_t;

	typedef enum logic [1:0] {
		LK_ONE,
		LK_ZERO,
		LK_QUO
	} lk_sel_t;

	typedef enum logic {
		RAT_ZERO,
		RAT_QUO
	} rat_sel_t;

	typedef enum logic [1:0] {
		OUT_HELD,
		OUT_FIN,
		OUT_SCALED
	} out_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_HELD_X,
		ST_LK_START,
		ST_LK_POS,
		ST_LK_CHK,
		ST_LK_RD2,
		ST_LK_MAC,
		ST_LK_SUM,
		ST_LK_IDIV,
		ST_LK_IWAIT,
		ST_LK_DONE,
		ST_HELD_CHK,
		ST_RATIO,
		ST_RWAIT,
		ST_SCALE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic     capture;
		logic     wr_entry;
		logic     set_x_held;
		logic     set_x_rel;
		logic     div_start;
		div_sel_t div_sel;
		logic     take_pos;
		logic     rd_en;
		logic     rd_next;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_init;
		logic     acc_add;
		logic     lk_en;
		lk_sel_t  lk_sel;
		logic     held_en;
		logic     ratio_en;
		rat_sel_t rat_sel;
		logic     out_load;
		out_sel_t out_sel;
	} cmd_t;

	typedef struct packed {
		logic action;
		logic released;
		logic total_zero;
		logic sus_zero;
		logic div_done;
		logic past_end;
		logic past_release;
		logic out_busy;
	} sts_t;

endpackage

// ----- hw/rtl/tdae_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
module tdae_div import tdae_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quo,
	output logic [DVS_W-1:0] rem
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;

	logic [DVS_W:0]   shifted;
	logic [DVS_W:0]   diff;
	logic             fits;
	logic [DVS_W-1:0] rem_n;

	always_comb begin
		shifted = {rem_q, quo_q[DIV_W-1]};
		diff    = shifted - {1'b0, dvs_q};
		fits    = shifted >= {1'b0, dvs_q};
		rem_n   = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= rem_n;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// ----- hw/rtl/tdae_dp.sv -----
// Envelope datapath: registers, shape table, multiplier, divider and output word.
module tdae_dp import tdae_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LVL_W-1:0]     cfg_data,
	input  logic                 action,
	input  logic [IDX_W-1:0]     entry_index,
	input  logic [LVL_W-1:0]     entry_level,
	input  logic [TIME_W-1:0]    time_now,
	input  logic                 released,
	input  logic [TIME_W-1:0]    release_time,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic [LVL_W-1:0]     level,
	output logic                 finished,
	input  cmd_t                 cmd,
	output sts_t                 sts
);

	logic [LEN_W-1:0] attack_q, hold_q, decay_q, release_q;
	logic [LVL_W-1:0] sustain_q;

	logic              rel_q;
	logic [TIME_W-1:0] now_q, rt_q;
	logic [TOT_W-1:0]  x_q;
	logic [PT_W:0]     point_q;
	logic [TOT_W-1:0]  rem_q;
	logic [LVL_W-1:0]  rd_q;
	logic [2*LVL_W-1:0] prod_q;
	logic [DIV_W-1:0]  acc_q;
	logic [LVL_W-1:0]  lk_q, held_q, ratio_q;
	logic              out_valid_q;
	logic [LVL_W-1:0]  level_q;
	logic              fin_q;

	logic [LVL_W-1:0]  table_mem [NUM_POINTS];

	logic [TOT_W-1:0]  sus_end, total, held_x, rel_x;
	logic [TIME_W-1:0] since, held_t;
	logic              last_pt;
	logic [PT_W-1:0]   rd_addr;
	logic              rd_fire;
	logic [DIV_W-1:0]  dvd;
	logic [DVS_W-1:0]  dvs;
	logic              div_done;
	logic [DIV_W-1:0]  div_quo;
	logic [DVS_W-1:0]  div_rem;
	logic [LVL_W-1:0]  mul_a, mul_b;
	logic [LVL_W-1:0]  ratio_sat;
	logic [2*LVL_W-1:0] rounded;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= '0;
			hold_q    <= '0;
			decay_q   <= '0;
			release_q <= '0;
			sustain_q <= ONE_Q16;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_ATTACK:  attack_q  <= cfg_data[LEN_W-1:0];
				CFG_HOLD:    hold_q    <= cfg_data[LEN_W-1:0];
				CFG_DECAY:   decay_q   <= cfg_data[LEN_W-1:0];
				CFG_RELEASE: release_q <= cfg_data[LEN_W-1:0];
				CFG_SUSTAIN: sustain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		sus_end = TOT_W'(attack_q) + TOT_W'(hold_q) + TOT_W'(decay_q);
		total   = sus_end + TOT_W'(release_q);
		since   = (now_q > rt_q) ? now_q - rt_q : '0;
		held_t  = rel_q ? rt_q : now_q;
		held_x  = (held_t < TIME_W'(sus_end)) ? held_t[TOT_W-1:0] : sus_end;
		// only used once since is known to be within the release length
		rel_x   = sus_end + since[TOT_W-1:0];
		last_pt = point_q == (PT_W+1)'(NUM_POINTS - 1);
		rd_addr = cmd.rd_next ? point_q[PT_W-1:0] + PT_W'(1) : point_q[PT_W-1:0];
		rd_fire = cmd.rd_en && !(cmd.rd_next && last_pt);
	end

	// shape table
	always_ff @(posedge clk) begin
		if (cmd.wr_entry && (32'(entry_index) < NUM_POINTS))
			table_mem[PT_W'(entry_index)] <= entry_level;
		if (rd_fire)
			rd_q <= table_mem[rd_addr];
	end

	// divider operands
	always_comb begin
		case (cmd.div_sel)
			DIV_POS: begin
				dvd = DIV_W'(x_q) * DIV_W'(NUM_POINTS);
				dvs = DVS_W'(total);
			end
			DIV_INTERP: begin
				dvd = acc_q;
				dvs = DVS_W'(total);
			end
			DIV_RATIO: begin
				dvd = {lk_q, {Q_FRAC{1'b0}}};
				dvs = sustain_q;
			end
			default: begin
				dvd = acc_q;
				dvs = DVS_W'(total);
			end
		endcase
	end

	tdae_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// multiplier operands
	always_comb begin
		case (cmd.mul_sel)
			MUL_Y1: begin
				mul_a = rd_q;
				mul_b = LVL_W'(total - rem_q);
			end
			MUL_Y2: begin
				mul_a = last_pt ? '0 : rd_q;
				mul_b = LVL_W'(rem_q);
			end
			MUL_RATIO: begin
				mul_a = held_q;
				mul_b = ratio_q;
			end
			default: begin
				mul_a = rd_q;
				mul_b = LVL_W'(rem_q);
			end
		endcase
		ratio_sat = (div_quo > DIV_W'(ONE_Q16)) ? ONE_Q16 : div_quo[LVL_W-1:0];
		rounded   = prod_q + HALF_Q16;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rel_q <= released;
			now_q <= time_now;
			rt_q  <= release_time;
		end
		if (cmd.set_x_held)
			x_q <= held_x;
		else if (cmd.set_x_rel)
			x_q <= rel_x;
		if (cmd.take_pos) begin
			point_q <= div_quo[PT_W:0];
			rem_q   <= div_rem[TOT_W-1:0];
		end
		if (cmd.mul_en)
			prod_q <= mul_a * mul_b;
		if (cmd.acc_init)
			acc_q <= prod_q[DIV_W-1:0] + DIV_W'(total >> 1);
		else if (cmd.acc_add)
			acc_q <= acc_q + prod_q[DIV_W-1:0];
		if (cmd.lk_en) begin
			case (cmd.lk_sel)
				LK_ONE:  lk_q <= ONE_Q16;
				LK_ZERO: lk_q <= '0;
				LK_QUO:  lk_q <= div_quo[LVL_W-1:0];
				default: lk_q <= '0;
			endcase
		end
		if (cmd.held_en)
			held_q <= lk_q;
		if (cmd.ratio_en)
			ratio_q <= (cmd.rat_sel == RAT_QUO) ? ratio_sat : '0;
		if (cmd.out_load) begin
			case (cmd.out_sel)
				OUT_HELD: begin
					level_q <= held_q;
					fin_q   <= 1'b0;
				end
				OUT_FIN: begin
					level_q <= '0;
					fin_q   <= 1'b1;
				end
				OUT_SCALED: begin
					level_q <= rounded[Q_FRAC+LVL_W-1:Q_FRAC];
					fin_q   <= 1'b0;
				end
				default: begin
					level_q <= '0;
					fin_q   <= 1'b0;
				end
			endcase
		end
	end

	// output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign level     = level_q;
	assign finished  = fin_q;

	always_comb begin
		sts.action       = action;
		sts.released     = rel_q;
		sts.total_zero   = total == '0;
		sts.sus_zero     = sustain_q == '0;
		sts.div_done     = div_done;
		sts.past_end     = point_q >= (PT_W+1)'(NUM_POINTS);
		sts.past_release = since > TIME_W'(release_q);
		sts.out_busy     = out_valid_q & out_stall;
	end

endmodule

// ----- hw/rtl/tdae_ctrl.sv -----
// Envelope controller: sequences table writes, lookups, ratio and output.
module tdae_ctrl import tdae_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t   state_q, state_n;
	logic     phase_q, phase_n;   // 0: level held now or at release, 1: release point
	out_sel_t osel_q, osel_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 1'b0;
			osel_q  <= OUT_HELD;
		end else begin
			state_q <= state_n;
			phase_q <= phase_n;
			osel_q  <= osel_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		phase_n  = phase_q;
		osel_n   = osel_q;
		cmd      = '0;
		in_stall = state_q != ST_IDLE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (sts.action)
						state_n = ST_HELD_X;
					else
						cmd.wr_entry = 1'b1;
				end
			end
			ST_HELD_X: begin
				cmd.set_x_held = 1'b1;
				phase_n        = 1'b0;
				state_n        = ST_LK_START;
			end
			ST_LK_START: begin
				if (sts.total_zero) begin
					cmd.lk_en  = 1'b1;
					cmd.lk_sel = LK_ONE;
					state_n    = ST_LK_DONE;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_POS;
					state_n       = ST_LK_POS;
				end
			end
			ST_LK_POS: begin
				if (sts.div_done) begin
					cmd.take_pos = 1'b1;
					state_n      = ST_LK_CHK;
				end
			end
			ST_LK_CHK: begin
				if (sts.past_end) begin
					cmd.lk_en  = 1'b1;
					cmd.lk_sel = LK_ZERO;
					state_n    = ST_LK_DONE;
				end else begin
					cmd.rd_en = 1'b1;
					state_n   = ST_LK_RD2;
				end
			end
			ST_LK_RD2: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_next = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_Y1;
				state_n     = ST_LK_MAC;
			end
			ST_LK_MAC: begin
				cmd.acc_init = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_Y2;
				state_n      = ST_LK_SUM;
			end
			ST_LK_SUM: begin
				cmd.acc_add = 1'b1;
				state_n     = ST_LK_IDIV;
			end
			ST_LK_IDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_INTERP;
				state_n       = ST_LK_IWAIT;
			end
			ST_LK_IWAIT: begin
				if (sts.div_done) begin
					cmd.lk_en  = 1'b1;
					cmd.lk_sel = LK_QUO;
					state_n    = ST_LK_DONE;
				end
			end
			ST_LK_DONE: begin
				if (!phase_q) begin
					cmd.held_en = 1'b1;
					state_n     = ST_HELD_CHK;
				end else begin
					state_n = ST_RATIO;
				end
			end
			ST_HELD_CHK: begin
				if (!sts.released) begin
					osel_n  = OUT_HELD;
					state_n = ST_OUT;
				end else if (sts.past_release) begin
					osel_n  = OUT_FIN;
					state_n = ST_OUT;
				end else begin
					cmd.set_x_rel = 1'b1;
					phase_n       = 1'b1;
					state_n       = ST_LK_START;
				end
			end
			ST_RATIO: begin
				if (sts.sus_zero) begin
					cmd.ratio_en = 1'b1;
					cmd.rat_sel  = RAT_ZERO;
					state_n      = ST_SCALE;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_RATIO;
					state_n       = ST_RWAIT;
				end
			end
			ST_RWAIT: begin
				cmd.div_sel = DIV_RATIO;
				if (sts.div_done) begin
					cmd.ratio_en = 1'b1;
					cmd.rat_sel  = RAT_QUO;
					state_n      = ST_SCALE;
				end
			end
			ST_SCALE: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_RATIO;
				osel_n      = OUT_SCALED;
				state_n     = ST_OUT;
			end
			ST_OUT: begin
				cmd.out_sel = osel_q;
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

endmodule

// ----- hw/rtl/table_driven_ahdsr_envelope_core.sv -----
// Top level of the table-driven AHDSR envelope core.
// A write word (action 0) stores one shape table entry, and the next word can follow at
// once. An evaluate word (action 1) occupies the core until its result is loaded into
// the output register; this takes longer after release than with the key held, and less
// when the total length is zero, a lookup lands at the table end or the release has run
// out. The time is set mostly by the 33-step serial divider, which each lookup uses twice
// (table position, interpolation) and the release ratio once more. The output register
// lets a new word be taken while the previous result still waits. Table entries must be
// written before any evaluation reads them; there is no clearing pass.
module table_driven_ahdsr_envelope_core import tdae_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LVL_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 action,
	input  logic [IDX_W-1:0]     entry_index,
	input  logic [LVL_W-1:0]     entry_level,
	input  logic [TIME_W-1:0]    time_now,
	input  logic                 released,
	input  logic [TIME_W-1:0]    release_time,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [LVL_W-1:0]     level,
	output logic                 finished
);

	cmd_t cmd;
	sts_t sts;

	tdae_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tdae_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.action       (action),
		.entry_index  (entry_index),
		.entry_level  (entry_level),
		.time_now     (time_now),
		.released     (released),
		.release_time (release_time),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.level        (level),
		.finished     (finished),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

// ----- hw/rtl/tdae_checker.sv -----
// Port-level checks for the envelope core, bound to the top level.
`include "table_driven_ahdsr_envelope_core_defines.svh"

module tdae_checker import tdae_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             action,
	input logic             out_valid,
	input logic             out_stall,
	input logic [LVL_W-1:0] level,
	input logic             finished
);

	// a finished word carries a zero level
	`TDAE_ASSERT_NOW(a_fin_zero, clk, arst_n, out_valid && finished, level == '0)

	// an accepted evaluate word holds off the next one
	`TDAE_ASSERT_NEXT(a_eval_busy, clk, arst_n, in_valid && !in_stall && action, in_stall)

	// a table write leaves the input open
	`TDAE_ASSERT_NEXT(a_write_open, clk, arst_n, in_valid && !in_stall && !action, !in_stall)

	// a stalled result stays put
	`TDAE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(level) && $stable(finished))

endmodule

bind table_driven_ahdsr_envelope_core tdae_checker u_tdae_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.action    (action),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.level     (level),
	.finished  (finished)
);
